@@ src/dgr_pkg.sv @@
`default_nettype none
package dgr_pkg;

    localparam int NODE_LIMIT    = 64;
    localparam int EDGE_CAPACITY = 256;
    localparam int EDGE_ADDR_W   = (EDGE_CAPACITY > 1) ? $clog2(EDGE_CAPACITY) : 1;
    localparam int EDGE_TOT_W    = $clog2(EDGE_CAPACITY + 1);
    localparam int NODE_W        = 6;
    localparam int QUEUE_DEPTH   = 64;
    localparam int QPTR_W        = 7;

    typedef enum logic [1:0] {
        FN_ADD = 2'd0,
        FN_FWD = 2'd1,
        FN_REV = 2'd2,
        FN_CLR = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        K_ADDED   = 3'd0,
        K_DUP     = 3'd1,
        K_RANGE   = 3'd2,
        K_FULL    = 3'd3,
        K_CLEARED = 3'd4,
        K_REACHED = 3'd5,
        K_NONE    = 3'd6
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD,
        ST_CLR,
        ST_NONE,
        ST_DEQ,
        ST_DEQW,
        ST_SCAN,
        ST_EDGE,
        ST_END
    } t_state;

endpackage
`default_nettype wire

@@ src/dgr_ram.sv @@
`default_nettype none
module dgr_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

@@ src/dependency_graph_reach_engine.sv @@
`default_nettype none
// Directed-graph reachability engine. Edges live in an append-only edge store
// (one registered-read RAM) plus a presence bitmap RAM whose rows carry valid
// flags, so a clear takes effect at once. One input transaction is taken at a
// time; the running time of a query is set by the single read port of the
// edge store, which is scanned once for every node taken from the walk
// queue. Results leave through an output register; node_count is to be
// written on the cfg channel at an idle time, which the block itself does
// not enforce, and is clamped to the node limit.
module dependency_graph_reach_engine (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [6:0]           i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [1:0]           i_func,
    input  wire logic [5:0]           i_src_node,
    input  wire logic [5:0]           i_dst_node,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [2:0]                o_kind,
    output logic [5:0]                o_node,
    output logic [5:0]                o_depth,
    output logic                      o_last
);
    import dgr_pkg::*;

    t_state                 r_state, n_state;
    t_func                  r_func, n_func;
    logic [NODE_W-1:0]      r_a, n_a, r_b, n_b;
    logic [6:0]             r_node_count;
    logic [63:0]            r_row_valid, n_row_valid;
    logic [EDGE_TOT_W-1:0]  r_total, n_total, r_e, n_e;
    logic [63:0]            r_visited, n_visited;
    logic [QPTR_W-1:0]      r_head, n_head, r_tail, n_tail;
    logic [NODE_W-1:0]      r_cur, n_cur, r_d, n_d;
    logic                   r_pend_valid, n_pend_valid;
    logic [NODE_W-1:0]      r_pend_node, n_pend_node, r_pend_depth, n_pend_depth;
    logic                   r_out_valid, n_out_valid;
    t_kind                  r_out_kind, n_out_kind;
    logic [NODE_W-1:0]      r_out_node, n_out_node, r_out_depth, n_out_depth;
    logic                   r_out_last, n_out_last;

    logic [6:0]             count;
    logic                   out_free;
    logic                   emit;
    t_kind                  e_kind;
    logic [NODE_W-1:0]      e_node, e_depth;
    logic                   e_last;

    logic                   pr_wr_en;
    logic [5:0]             pr_rd_addr;
    logic [63:0]            pr_wr_data, pr_rd_data, row;
    logic                   el_wr_en;
    logic [11:0]            el_rd_data;
    logic                   wq_wr_en;
    logic [5:0]             wq_wr_addr;
    logic [11:0]            wq_wr_data, wq_rd_data;
    t_kind                  add_kind;
    logic [NODE_W-1:0]      near, far;
    logic                   hit;

    dgr_ram #(.WIDTH(64), .DEPTH(64)) u_present (
        .i_clk     (i_clk),
        .i_wr_en   (pr_wr_en),
        .i_wr_addr (r_a),
        .i_wr_data (pr_wr_data),
        .i_rd_addr (pr_rd_addr),
        .o_rd_data (pr_rd_data)
    );

    dgr_ram #(.WIDTH(12), .DEPTH(EDGE_CAPACITY)) u_edges (
        .i_clk     (i_clk),
        .i_wr_en   (el_wr_en),
        .i_wr_addr (r_total[EDGE_ADDR_W-1:0]),
        .i_wr_data ({r_a, r_b}),
        .i_rd_addr (r_e[EDGE_ADDR_W-1:0]),
        .o_rd_data (el_rd_data)
    );

    dgr_ram #(.WIDTH(12), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk     (i_clk),
        .i_wr_en   (wq_wr_en),
        .i_wr_addr (wq_wr_addr),
        .i_wr_data (wq_wr_data),
        .i_rd_addr (r_head[5:0]),
        .o_rd_data (wq_rd_data)
    );

    assign count       = (r_node_count > 7'(NODE_LIMIT)) ? 7'(NODE_LIMIT) : r_node_count;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign pr_rd_addr  = (r_state == ST_IDLE) ? i_src_node : r_a;
    assign row         = r_row_valid[r_a] ? pr_rd_data : 64'd0;
    assign pr_wr_data  = row | (64'd1 << r_b);

    always_comb begin
        if ({1'b0, r_a} >= count || {1'b0, r_b} >= count) begin
            add_kind = K_RANGE;
        end else if (row[r_b]) begin
            add_kind = K_DUP;
        end else if (r_total >= EDGE_TOT_W'(EDGE_CAPACITY)) begin
            add_kind = K_FULL;
        end else begin
            add_kind = K_ADDED;
        end
    end

    // reverse walks follow edges from target back to source
    assign near = (r_func == FN_REV) ? el_rd_data[5:0]  : el_rd_data[11:6];
    assign far  = (r_func == FN_REV) ? el_rd_data[11:6] : el_rd_data[5:0];
    assign hit  = (near == r_cur) && ({1'b0, far} < count) && !r_visited[far];

    always_comb begin
        n_state      = r_state;
        n_func       = r_func;
        n_a          = r_a;
        n_b          = r_b;
        n_row_valid  = r_row_valid;
        n_total      = r_total;
        n_e          = r_e;
        n_visited    = r_visited;
        n_head       = r_head;
        n_tail       = r_tail;
        n_cur        = r_cur;
        n_d          = r_d;
        n_pend_valid = r_pend_valid;
        n_pend_node  = r_pend_node;
        n_pend_depth = r_pend_depth;
        emit         = 1'b0;
        e_kind       = K_NONE;
        e_node       = '0;
        e_depth      = '0;
        e_last       = 1'b1;
        pr_wr_en     = 1'b0;
        el_wr_en     = 1'b0;
        wq_wr_en     = 1'b0;
        wq_wr_addr   = r_tail[5:0];
        wq_wr_data   = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_func = t_func'(i_func);
                    n_a    = i_src_node;
                    n_b    = i_dst_node;
                    unique case (t_func'(i_func))
                        FN_ADD: n_state = ST_ADD;
                        FN_CLR: n_state = ST_CLR;
                        FN_FWD, FN_REV: begin
                            if ({1'b0, i_src_node} >= count) begin
                                n_state = ST_NONE;
                            end else begin
                                wq_wr_en     = 1'b1;
                                wq_wr_addr   = '0;
                                wq_wr_data   = {i_src_node, 6'd0};
                                n_visited    = 64'd1 << i_src_node;
                                n_head       = '0;
                                n_tail       = QPTR_W'(1);
                                n_pend_valid = 1'b0;
                                n_state      = ST_DEQ;
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_ADD: begin
                if (out_free) begin
                    emit   = 1'b1;
                    e_kind = add_kind;
                    if (add_kind == K_ADDED) begin
                        pr_wr_en         = 1'b1;
                        n_row_valid[r_a] = 1'b1;
                        el_wr_en         = 1'b1;
                        n_total          = r_total + 1'b1;
                    end
                    n_state = ST_IDLE;
                end
            end
            ST_CLR: begin
                if (out_free) begin
                    emit        = 1'b1;
                    e_kind      = K_CLEARED;
                    n_row_valid = '0;
                    n_total     = '0;
                    n_state     = ST_IDLE;
                end
            end
            ST_NONE: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_DEQ: begin
                n_state = (r_head == r_tail) ? ST_END : ST_DEQW;
            end
            ST_DEQW: begin
                n_cur   = wq_rd_data[11:6];
                n_d     = wq_rd_data[5:0];
                n_head  = r_head + 1'b1;
                n_e     = '0;
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                n_state = (r_e == r_total) ? ST_DEQ : ST_EDGE;
            end
            ST_EDGE: begin
                if (!hit) begin
                    n_e     = r_e + 1'b1;
                    n_state = ST_SCAN;
                end else if (!r_pend_valid || out_free) begin
                    // the held result goes out only once a later one proves it is not last
                    if (r_pend_valid) begin
                        emit    = 1'b1;
                        e_kind  = K_REACHED;
                        e_node  = r_pend_node;
                        e_depth = r_pend_depth;
                        e_last  = 1'b0;
                    end
                    n_pend_valid   = 1'b1;
                    n_pend_node    = far;
                    n_pend_depth   = r_d + 1'b1;
                    n_visited[far] = 1'b1;
                    wq_wr_en       = 1'b1;
                    wq_wr_data     = {far, r_d + 6'd1};
                    n_tail         = r_tail + 1'b1;
                    n_e            = r_e + 1'b1;
                    n_state        = ST_SCAN;
                end
            end
            ST_END: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (r_pend_valid) begin
                        e_kind  = K_REACHED;
                        e_node  = r_pend_node;
                        e_depth = r_pend_depth;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        n_out_kind  = r_out_kind;
        n_out_node  = r_out_node;
        n_out_depth = r_out_depth;
        n_out_last  = r_out_last;
        if (emit) begin
            n_out_valid = 1'b1;
            n_out_kind  = e_kind;
            n_out_node  = e_node;
            n_out_depth = e_depth;
            n_out_last  = e_last;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_node_count <= 7'(NODE_LIMIT);
            r_row_valid  <= '0;
            r_total      <= '0;
            r_head       <= '0;
            r_tail       <= '0;
            r_e          <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            if (i_cfg_valid) begin
                r_node_count <= i_cfg_data;
            end
            r_row_valid  <= n_row_valid;
            r_total      <= n_total;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_e          <= n_e;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func       <= n_func;
        r_a          <= n_a;
        r_b          <= n_b;
        r_visited    <= n_visited;
        r_cur        <= n_cur;
        r_d          <= n_d;
        r_pend_node  <= n_pend_node;
        r_pend_depth <= n_pend_depth;
        r_out_kind   <= n_out_kind;
        r_out_node   <= n_out_node;
        r_out_depth  <= n_out_depth;
        r_out_last   <= n_out_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_node      = r_out_node;
    assign o_depth     = r_out_depth;
    assign o_last      = r_out_last;

    a_tail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail <= QPTR_W'(QUEUE_DEPTH))
        else $error("walk queue tail beyond queue depth");

    a_head_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DEQ || r_state == ST_SCAN || r_state == ST_EDGE) |-> r_head <= r_tail)
        else $error("walk queue head passed tail");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN || r_state == ST_EDGE) |-> r_e <= r_total)
        else $error("edge scan beyond stored edges");

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= EDGE_TOT_W'(EDGE_CAPACITY))
        else $error("edge count beyond capacity");

endmodule
`default_nettype wire
